FILE: rtl/ipdf_pkg.sv
// Package: shared types and constants of the IPv4 destination-port drop filter.
`timescale 1ns / 1ps

package ipdf_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;

   localparam logic [6:0] POS_ETYPE_HI = 7'd12;
   localparam logic [6:0] POS_ETYPE_LO = 7'd13;
   localparam logic [6:0] POS_IHL      = 7'd14;
   localparam logic [6:0] POS_PROTO    = 7'd23;
   localparam logic [6:0] POS_PORT_MIN = 7'd16;
   localparam logic [6:0] POS_MAX      = 7'd127;
   localparam logic [6:0] ETH_HDR_LEN  = 7'd14;
   localparam logic [7:0] MIN_IP_FRAME = 8'd34;
   localparam logic [7:0] TCP_HDR_LEN  = 8'd20;
   localparam logic [7:0] UDP_HDR_LEN  = 8'd8;

   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam logic CSR_IDX_BLOCKED_PORT = 1'b0;

   typedef struct packed {
      logic drop;
   } verdict_type;

   typedef struct packed {
      logic        valid;
      verdict_type entry;
   } queue_head_type;

endpackage

FILE: rtl/ipdf_parser.sv
// Front end: byte-position tracking, header field capture and drop classification.
`timescale 1ns / 1ps

module ipdf_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           frame_byte,
   input  logic                 end_of_frame,
   input  logic                 accept,
   input  logic [15:0]          blocked_port,
   output logic                 push,
   output ipdf_pkg::verdict_type push_data
);
   import ipdf_pkg::*;

   logic [6:0]  pos_ff, pos_in;
   logic [15:0] etype_ff, etype_in;
   logic [3:0]  hwords_ff, hwords_in;
   logic [7:0]  proto_ff, proto_in;
   logic [15:0] port_ff, port_in;
   logic [6:0]  toff_cur;
   logic [6:0]  toff_new;
   logic [7:0]  frame_len;
   logic        room;
   logic        drop;

   always_comb begin
      etype_in  = etype_ff;
      hwords_in = hwords_ff;
      proto_in  = proto_ff;
      port_in   = port_ff;
      toff_cur  = ETH_HDR_LEN + {1'b0, hwords_ff, 2'b00};

      if (pos_ff == POS_ETYPE_HI) begin
         etype_in[15:8] = frame_byte;
      end else if (pos_ff == POS_ETYPE_LO) begin
         etype_in[7:0] = frame_byte;
      end
      if (pos_ff == POS_IHL) begin
         hwords_in = frame_byte[3:0];
      end
      if (pos_ff == POS_PROTO) begin
         proto_in = frame_byte;
      end
      if (pos_ff >= POS_PORT_MIN) begin
         if (pos_ff == toff_cur + 7'd2) begin
            port_in[15:8] = frame_byte;
         end else if (pos_ff == toff_cur + 7'd3) begin
            port_in[7:0] = frame_byte;
         end
      end

      // decision uses the fields as updated by the final byte
      toff_new  = ETH_HDR_LEN + {1'b0, hwords_in, 2'b00};
      frame_len = {1'b0, pos_ff} + 8'd1;
      if (proto_in == PROTO_TCP) begin
         room = frame_len >= ({1'b0, toff_new} + TCP_HDR_LEN);
      end else if (proto_in == PROTO_UDP) begin
         room = frame_len >= ({1'b0, toff_new} + UDP_HDR_LEN);
      end else begin
         room = 1'b0;
      end
      drop = (blocked_port != 16'd0) && (frame_len >= MIN_IP_FRAME) &&
             (etype_in == ETHERTYPE_IPV4) && room && (port_in == blocked_port);

      pos_in = (pos_ff < POS_MAX) ? pos_ff + 7'd1 : pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         etype_ff  <= '0;
         hwords_ff <= '0;
         proto_ff  <= '0;
         port_ff   <= '0;
      end else if (accept) begin
         if (end_of_frame) begin
            pos_ff    <= '0;
            etype_ff  <= '0;
            hwords_ff <= '0;
            proto_ff  <= '0;
            port_ff   <= '0;
         end else begin
            pos_ff    <= pos_in;
            etype_ff  <= etype_in;
            hwords_ff <= hwords_in;
            proto_ff  <= proto_in;
            port_ff   <= port_in;
         end
      end
   end

   assign push           = accept && end_of_frame;
   assign push_data.drop = drop;

endmodule

FILE: rtl/ipdf_queue.sv
// Short verdict queue between the parser and the counter stage.
`timescale 1ns / 1ps

module ipdf_queue #(
   parameter int unsigned DEPTH = ipdf_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ipdf_pkg::verdict_type   push_data,
   input  logic                    pop,
   output logic                    full,
   output ipdf_pkg::queue_head_type head
);
   import ipdf_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   verdict_type      entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head.valid = (count_ff != '0);
   assign head.entry = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
      end
   end

endmodule

FILE: rtl/ipdf_counter.sv
// Back end: frame and drop counters with the result output register.
`timescale 1ns / 1ps

module ipdf_counter (
   input  logic                     clock,
   input  logic                     reset,
   input  ipdf_pkg::queue_head_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_drop_verdict,
   output logic [63:0]              rsp_frames_seen,
   output logic [63:0]              rsp_frames_dropped
);
   import ipdf_pkg::*;

   logic        out_valid_ff;
   logic        verdict_ff;
   logic [63:0] packet_total_ff, packet_total_in;
   logic [63:0] drop_total_ff, drop_total_in;

   assign pop             = head.valid && (!out_valid_ff || !rsp_stall);
   assign packet_total_in = packet_total_ff + 64'd1;
   assign drop_total_in   = drop_total_ff + {63'd0, head.entry.drop};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff    <= 1'b0;
         verdict_ff      <= 1'b0;
         packet_total_ff <= '0;
         drop_total_ff   <= '0;
      end else if (pop) begin
         out_valid_ff    <= 1'b1;
         verdict_ff      <= head.entry.drop;
         packet_total_ff <= packet_total_in;
         drop_total_ff   <= drop_total_in;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_drop_verdict   = verdict_ff;
   assign rsp_frames_seen    = packet_total_ff;
   assign rsp_frames_dropped = drop_total_ff;

endmodule

FILE: rtl/ipv4_port_drop_filter.sv
// Top level: IPv4 TCP/UDP destination-port drop filter with APB register port.
// Accepts one frame byte per cycle while req_stall is low; req_stall rises only when the
// verdict queue is full. Each verdict passes the verdict queue and then the result register;
// rsp_valid rises when that register is loaded while the output is free, and a held result
// keeps later verdicts in the queue (QUEUE_DEPTH deep). Synchronous active-high reset clears
// position, captured fields, counters and blocked_port; bytes are accepted right after reset.
`timescale 1ns / 1ps

module ipv4_port_drop_filter #(
   parameter int unsigned QUEUE_DEPTH = ipdf_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_frame_byte,
   input  logic                                req_end_of_frame,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_drop_verdict,
   output logic [63:0]                         rsp_frames_seen,
   output logic [63:0]                         rsp_frames_dropped,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ipdf_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import ipdf_pkg::*;

   logic [15:0]    blocked_port_reg_ff;
   logic           csr_write;
   logic           accept;
   logic           push;
   verdict_type    push_data;
   logic           pop;
   logic           queue_full;
   queue_head_type head;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_port_reg_ff <= '0;
      end else begin
         if (csr_write && (csr_paddr[2] == CSR_IDX_BLOCKED_PORT)) begin
            blocked_port_reg_ff <= csr_pwdata[15:0];
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_BLOCKED_PORT) begin
         csr_prdata = {16'd0, blocked_port_reg_ff};
      end
   end

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   ipdf_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .frame_byte   (req_frame_byte),
      .end_of_frame (req_end_of_frame),
      .accept       (accept),
      .blocked_port (blocked_port_reg_ff),
      .push         (push),
      .push_data    (push_data)
   );

   ipdf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (queue_full),
      .head      (head)
   );

   ipdf_counter u_counter (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drop_verdict   (rsp_drop_verdict),
      .rsp_frames_seen    (rsp_frames_seen),
      .rsp_frames_dropped (rsp_frames_dropped)
   );

endmodule

FILE: verif/tb.sv
// Testbench for ipv4_port_drop_filter: frame stimulus, APB port setup and verdict checking.
`timescale 1ns / 1ps

module tb;
   import ipdf_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned PHASES = 7;
   localparam int unsigned PHASE_BYTES = 200;
   localparam int unsigned PHASE_FRAMES = 3;
   localparam int unsigned MAX_IDLE = 11;
   localparam int unsigned LONG_HOLD = 200;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_BLOCKED_PORT =
      CSR_ADDR_WIDTH'(4 * CSR_IDX_BLOCKED_PORT);
   // next register slot; no register lives there
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_UNMAPPED = CSR_ADDR_WIDTH'(4);

   typedef struct packed {
      logic        drop;
      logic [63:0] seen;
      logic [63:0] dropped;
   } frame_verdict_type;

   class port_filter_scoreboard;
      logic [15:0] blocked_port;
      logic [6:0]  position;
      logic [15:0] ether_type;
      logic [3:0]  header_words;
      logic [7:0]  protocol;
      logic [15:0] dest_port;
      logic [63:0] frames_total;
      logic [63:0] drops_total;
      frame_verdict_type verdicts_due[$];
      int unsigned mismatches;
      int unsigned frames_checked;
      int unsigned drops_checked;

      function new();
         blocked_port = '0;
         frames_total = '0;
         drops_total = '0;
         mismatches = 0;
         frames_checked = 0;
         drops_checked = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         position = '0;
         ether_type = '0;
         header_words = '0;
         protocol = '0;
         dest_port = '0;
      endfunction

      function void write_register(logic [CSR_ADDR_WIDTH-1:0] addr, logic [31:0] data);
         if (addr == ADDR_BLOCKED_PORT) begin
            blocked_port = data[15:0];
         end
      endfunction

      function bit frame_drops(int unsigned len);
         int unsigned toff;
         bit room;
         toff = int'(ETH_HDR_LEN) + 4 * header_words;
         if (blocked_port == 16'h0000) return 1'b0;
         if (len < MIN_IP_FRAME) return 1'b0;
         if (ether_type != ETHERTYPE_IPV4) return 1'b0;
         if (protocol == PROTO_TCP) begin
            room = len >= toff + TCP_HDR_LEN;
         end else if (protocol == PROTO_UDP) begin
            room = len >= toff + UDP_HDR_LEN;
         end else begin
            return 1'b0;
         end
         return room && (dest_port == blocked_port);
      endfunction

      function void note_byte(logic [7:0] value, logic last);
         int unsigned toff;
         int unsigned len;
         frame_verdict_type verdict;
         toff = int'(ETH_HDR_LEN) + 4 * header_words;
         if (position == POS_ETYPE_HI) begin
            ether_type[15:8] = value;
         end else if (position == POS_ETYPE_LO) begin
            ether_type[7:0] = value;
         end
         if (position == POS_IHL) header_words = value[3:0];
         if (position == POS_PROTO) protocol = value;
         if (position >= POS_PORT_MIN) begin
            if (position == toff + 2) begin
               dest_port[15:8] = value;
            end else if (position == toff + 3) begin
               dest_port[7:0] = value;
            end
         end
         if (!last) begin
            if (position != POS_MAX) position = position + 1'b1;
            return;
         end
         len = {25'd0, position} + 32'd1;
         verdict.drop = frame_drops(len);
         frames_total = frames_total + 1;
         if (verdict.drop) drops_total = drops_total + 1;
         verdict.seen = frames_total;
         verdict.dropped = drops_total;
         verdicts_due.push_back(verdict);
         clear_frame();
      endfunction

      function void check_verdict(logic drop, logic [63:0] seen, logic [63:0] dropped);
         frame_verdict_type due;
         if (verdicts_due.size() == 0) begin
            $error("verdict transfer with none pending: drop %0b seen %0d dropped %0d",
                   drop, seen, dropped);
            mismatches++;
            return;
         end
         due = verdicts_due.pop_front();
         frames_checked++;
         if (due.drop) drops_checked++;
         if (drop !== due.drop) begin
            $error("drop_verdict: expected %0b, got %0b", due.drop, drop);
            mismatches++;
         end
         if (seen !== due.seen) begin
            $error("frames_seen: expected %0d, got %0d", due.seen, seen);
            mismatches++;
         end
         if (dropped !== due.dropped) begin
            $error("frames_dropped: expected %0d, got %0d", due.dropped, dropped);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return verdicts_due.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_frame_byte = '0;
   logic req_end_of_frame = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_drop_verdict;
   logic [63:0] rsp_frames_seen;
   logic [63:0] rsp_frames_dropped;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   port_filter_scoreboard scoreboard;
   logic [7:0] frame_bytes[$];
   bit sender_idle;
   bit receiver_idle;
   int unsigned hold_request;
   int unsigned stall_left;
   int unsigned cycle_count;
   int unsigned backpressure_cycles;
   int unsigned byte_transfers;
   int unsigned frames_sent;
   int unsigned phase_bytes_start;
   int unsigned phase_frames_start;
   logic [15:0] port_plan[PHASES];
   logic [31:0] read_data;

   ipv4_port_drop_filter i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_frame_byte     (req_frame_byte),
      .req_end_of_frame   (req_end_of_frame),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_drop_verdict   (rsp_drop_verdict),
      .rsp_frames_seen    (rsp_frames_seen),
      .rsp_frames_dropped (rsp_frames_dropped),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (req_valid && req_stall) backpressure_cycles++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL ipv4_port_drop_filter");
         $finish;
      end
   end

   // verdict receiver: random stall after each transfer when receiver_idle is set, or a long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            scoreboard.check_verdict(rsp_drop_verdict, rsp_frames_seen, rsp_frames_dropped);
            stall_left = receiver_idle ? $urandom_range(0, MAX_IDLE) : 0;
         end
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic csr_access(input logic write_en, input logic [CSR_ADDR_WIDTH-1:0] addr,
                             input logic [31:0] data, output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write_en;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      if (write_en) scoreboard.write_register(addr, data);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic verify_port_register();
      logic [31:0] rdata;
      csr_access(1'b0, ADDR_BLOCKED_PORT, '0, rdata);
      if (rdata[15:0] !== scoreboard.blocked_port) begin
         $error("blocked_port: expected %0d, got %0d", scoreboard.blocked_port, rdata[15:0]);
         scoreboard.mismatches++;
      end
   endtask

   task automatic send_byte(input logic [7:0] value, input logic last);
      int unsigned gap;
      gap = sender_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_frame_byte <= value;
      req_end_of_frame <= last;
      do @(posedge clock); while (req_stall);
      scoreboard.note_byte(value, last);
      byte_transfers++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_bytes.size(); i++) begin
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      end
      frames_sent++;
   endtask

   function automatic void build_frame(int unsigned len, logic [15:0] etype,
                                       logic [7:0] ihl_byte, logic [7:0] proto,
                                       logic [15:0] port);
      int unsigned toff;
      toff = int'(ETH_HDR_LEN) + 4 * ihl_byte[3:0];
      frame_bytes.delete();
      repeat (len) frame_bytes.push_back(8'($urandom));
      if (len > POS_ETYPE_HI) frame_bytes[POS_ETYPE_HI] = etype[15:8];
      if (len > POS_ETYPE_LO) frame_bytes[POS_ETYPE_LO] = etype[7:0];
      if (len > POS_IHL) frame_bytes[POS_IHL] = ihl_byte;
      if (len > POS_PROTO) frame_bytes[POS_PROTO] = proto;
      if (len > toff + 2) frame_bytes[toff + 2] = port[15:8];
      if (len > toff + 3) frame_bytes[toff + 3] = port[7:0];
   endfunction

   task automatic send_random_frame();
      int unsigned kind;
      int unsigned len;
      int unsigned need;
      logic [3:0] ihl;
      logic [3:0] version;
      logic [7:0] proto;
      logic [15:0] etype;
      logic [15:0] port;
      kind = $urandom_range(0, 15);
      if (kind < 3) begin
         // noise: short frame, all content random
         build_frame($urandom_range(1, 33), 16'($urandom), 8'($urandom), 8'($urandom),
                     16'($urandom));
      end else begin
         etype = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ETHERTYPE_IPV4;
         ihl = ($urandom_range(0, 3) != 0) ? 4'd5 : 4'($urandom);
         version = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'h4;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: proto = PROTO_TCP;
            4, 5, 6, 7: proto = PROTO_UDP;
            default: proto = 8'($urandom);
         endcase
         case ($urandom_range(0, 5))
            0: port = 16'($urandom);
            1: port = scoreboard.blocked_port ^ (16'h0001 << $urandom_range(0, 15));
            default: port = scoreboard.blocked_port;
         endcase
         need = int'(ETH_HDR_LEN) + 4 * ihl + ((proto == PROTO_TCP) ? TCP_HDR_LEN : UDP_HDR_LEN);
         case ($urandom_range(0, 9))
            0: len = need - 1;
            1: len = need;
            2: len = MIN_IP_FRAME - $urandom_range(0, 1);
            3: len = $urandom_range(120, 150);
            default: len = need + $urandom_range(0, 24);
         endcase
         build_frame(len, etype, {version, ihl}, proto, port);
      end
      send_frame();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      scoreboard = new();
      hold_request = 0;
      cycle_count = 0;
      backpressure_cycles = 0;
      byte_transfers = 0;
      frames_sent = 0;
      port_plan[0] = 16'h0000;
      port_plan[1] = 16'hFFFF;
      port_plan[2] = 16'($urandom_range(1, 65535));
      port_plan[3] = 16'h0001;
      port_plan[4] = 16'($urandom_range(1, 65535));
      port_plan[5] = 16'h0000;
      port_plan[6] = 16'($urandom_range(1, 65535));
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      verify_port_register();
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            csr_access(1'b1, ADDR_BLOCKED_PORT, {16'($urandom), port_plan[phase]}, read_data);
            verify_port_register();
         end
         if (phase == 3) begin
            csr_access(1'b1, ADDR_UNMAPPED, 32'($urandom), read_data);
            verify_port_register();
         end
         sender_idle = (phase % 3) != 1;
         receiver_idle = (phase % 2) == 0;
         if (phase == 1) begin
            frame_bytes = {8'h00};
            send_frame();
            frame_bytes = {8'hFF};
            send_frame();
            // UDP, standard header, exact length -> drop
            build_frame(42, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 16'hFFFF);
            send_frame();
            // TCP one byte short of the transport header -> pass
            build_frame(53, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 16'hFFFF);
            send_frame();
            // zero header length: port bytes inside the IP header
            build_frame(34, ETHERTYPE_IPV4, 8'h40, PROTO_UDP, 16'hFFFF);
            send_frame();
         end
         if (phase == 2) begin
            // receiver holds off while short frames stream in back to back
            sender_idle = 1'b0;
            hold_request = LONG_HOLD;
            repeat (24) begin
               build_frame($urandom_range(1, 4), 16'($urandom), 8'($urandom), 8'($urandom),
                           16'($urandom));
               send_frame();
            end
            sender_idle = 1'b1;
         end
         phase_bytes_start = byte_transfers;
         phase_frames_start = frames_sent;
         while (byte_transfers - phase_bytes_start < PHASE_BYTES ||
                frames_sent - phase_frames_start < PHASE_FRAMES) begin
            send_random_frame();
         end
         drain();
      end
      $display("Checked %0d verdicts (%0d drops) from %0d byte transfers over %0d port settings",
               scoreboard.frames_checked, scoreboard.drops_checked, byte_transfers, PHASES);
      $display("Input backpressure held for %0d cycles", backpressure_cycles);
      if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
         $display("PASS ipv4_port_drop_filter");
      end else begin
         $display("FAIL ipv4_port_drop_filter");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/ipdf_pkg.sv
rtl/ipdf_parser.sv
rtl/ipdf_queue.sv
rtl/ipdf_counter.sv
rtl/ipv4_port_drop_filter.sv
verif/tb.sv
